// ----- hw/rtl/byte_stuffing_frame_decoder_unit_macros.svh -----
// Assertion helpers for the byte stuffing frame decoder.
`ifndef BYTE_STUFFING_FRAME_DECODER_UNIT_MACROS_SVH
`define BYTE_STUFFING_FRAME_DECODER_UNIT_MACROS_SVH

// expr must never hold while out of reset
`define BSFD_ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("bsfd: forbidden condition seen");

// ante in a cycle requires cons in the same cycle
`define BSFD_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bsfd: implication failed");

// ante in a cycle requires cons in the next cycle
`define BSFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bsfd: next-cycle implication failed");

`endif

// ----- hw/rtl/bsfd_pkg.sv -----
`default_nettype none

package bsfd_pkg;

  localparam int FRAME_BYTES_DEF = 16;

  localparam int CODE_W  = 8;
  localparam int KIND_W  = 2;
  localparam int POS_W   = 4;
  localparam int INDEX_W = 2;

  localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SHORT   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LONG    = 2'd2;

  localparam logic [INDEX_W-1:0] REG_BEGIN  = 2'd0;
  localparam logic [INDEX_W-1:0] REG_END    = 2'd1;
  localparam logic [INDEX_W-1:0] REG_ESCAPE = 2'd2;

  localparam logic [CODE_W-1:0] BEGIN_RST  = 8'd2;
  localparam logic [CODE_W-1:0] END_RST    = 8'd3;
  localparam logic [CODE_W-1:0] ESCAPE_RST = 8'd27;

  typedef struct packed {
    logic take;
    logic burst_start;
    logic rd_issue;
    logic rd_move;
  } bsfd_cmd_t;

  typedef struct packed {
    logic release_hit;
    logic rd_all_issued;
    logic rd_vld;
    logic rd_last;
    logic out_free;
  } bsfd_sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/bsfd_ctrl.sv -----
`default_nettype none

module bsfd_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire bsfd_pkg::bsfd_sts_t sts,
  output bsfd_pkg::bsfd_cmd_t      cmd
);
  import bsfd_pkg::*;

  typedef enum logic {
    S_RUN,
    S_BURST
  } state_t;

  state_t state;

  always_comb begin
    cmd.take        = (state == S_RUN) && in_valid && sts.out_free;
    cmd.burst_start = cmd.take && sts.release_hit;
    cmd.rd_issue    = (state == S_BURST) && !sts.rd_all_issued &&
                      (!sts.rd_vld || sts.out_free);
    cmd.rd_move     = (state == S_BURST) && sts.rd_vld && sts.out_free;
    in_stall        = (state != S_RUN) || !sts.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RUN;
    end else begin
      case (state)
        S_RUN: begin
          if (cmd.burst_start) begin
            state <= S_BURST;
          end
        end
        S_BURST: begin
          if (cmd.rd_move && sts.rd_last) begin
            state <= S_RUN;
          end
        end
        default: state <= S_RUN;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/bsfd_dp.sv -----
`default_nettype none

module bsfd_dp #(
  parameter int FRAME_BYTES = bsfd_pkg::FRAME_BYTES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_wr_en,
  input  wire logic [bsfd_pkg::INDEX_W-1:0]  cfg_index,
  input  wire logic [bsfd_pkg::CODE_W-1:0]   cfg_data,
  input  wire logic [bsfd_pkg::CODE_W-1:0]   rx_byte,
  input  wire bsfd_pkg::bsfd_cmd_t           cmd,
  output bsfd_pkg::bsfd_sts_t                sts,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [bsfd_pkg::KIND_W-1:0]        kind,
  output logic [bsfd_pkg::CODE_W-1:0]        payload,
  output logic [bsfd_pkg::POS_W-1:0]         position,
  output logic                               last
);
  import bsfd_pkg::*;

  localparam int IW = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
  localparam int CW = $clog2(FRAME_BYTES + 1);
  localparam logic [CW-1:0] FULL     = CW'(FRAME_BYTES);
  localparam logic [CW-1:0] LAST_IDX = CW'(FRAME_BYTES - 1);

  logic [CODE_W-1:0] begin_code;
  logic [CODE_W-1:0] end_code;
  logic [CODE_W-1:0] escape_code;

  logic          in_frame;
  logic          esc_pending;
  logic          prev_esc;
  logic [CW-1:0] fill;

  logic [CODE_W-1:0] mem [FRAME_BYTES];

  logic [CW-1:0]     rd_cnt;
  logic              rd_vld;
  logic [CODE_W-1:0] rd_data;
  logic [IW-1:0]     rd_pos;
  logic              rd_last;

  logic is_begin;
  logic is_end;
  logic is_esc;
  logic full;
  logic out_free;

  logic store;
  logic emit;
  logic [KIND_W-1:0] emit_kind;

  always_comb begin
    is_begin = (rx_byte == begin_code);
    is_end   = (rx_byte == end_code);
    is_esc   = (rx_byte == escape_code);
    full     = (fill == FULL);
    out_free = !out_valid || !out_stall;

    store     = 1'b0;
    emit      = 1'b0;
    emit_kind = KIND_SHORT;
    if (cmd.take && in_frame) begin
      if (full) begin
        emit      = !is_end;
        emit_kind = KIND_LONG;
      end else if (esc_pending) begin
        store = 1'b1;
      end else if (is_esc) begin
        store = 1'b0;
      end else if (is_end) begin
        emit      = 1'b1;
        emit_kind = KIND_SHORT;
      end else if (!is_begin) begin
        store = 1'b1;
      end
    end

    sts.release_hit   = in_frame && full && is_end;
    sts.rd_all_issued = (rd_cnt == FULL);
    sts.rd_vld        = rd_vld;
    sts.rd_last       = rd_last;
    sts.out_free      = out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      begin_code  <= BEGIN_RST;
      end_code    <= END_RST;
      escape_code <= ESCAPE_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_BEGIN:  begin_code  <= cfg_data;
        REG_END:    end_code    <= cfg_data;
        REG_ESCAPE: escape_code <= cfg_data;
        default: ;
      endcase
    end
  end

  // frame parsing state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame    <= 1'b0;
      esc_pending <= 1'b0;
      prev_esc    <= 1'b0;
      fill        <= '0;
    end else if (cmd.take) begin
      prev_esc <= is_esc;
      if (!in_frame) begin
        if (is_begin && !prev_esc) begin
          in_frame    <= 1'b1;
          esc_pending <= 1'b0;
          fill        <= '0;
        end
      end else if (full || (!esc_pending && !is_esc && is_end)) begin
        in_frame    <= 1'b0;
        esc_pending <= 1'b0;
        fill        <= '0;
      end else if (esc_pending) begin
        esc_pending <= 1'b0;
        fill        <= fill + CW'(1);
      end else if (is_esc) begin
        esc_pending <= 1'b1;
      end else if (!is_begin) begin
        fill <= fill + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (store) begin
      mem[fill[IW-1:0]] <= rx_byte;
    end
    if (cmd.rd_issue) begin
      rd_data <= mem[rd_cnt[IW-1:0]];
      rd_pos  <= rd_cnt[IW-1:0];
      rd_last <= (rd_cnt == LAST_IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_cnt <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (cmd.burst_start) begin
        rd_cnt <= '0;
      end else if (cmd.rd_issue) begin
        rd_cnt <= rd_cnt + CW'(1);
      end
      if (cmd.rd_issue) begin
        rd_vld <= 1'b1;
      end else if (cmd.rd_move) begin
        rd_vld <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit || cmd.rd_move) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      kind     <= emit_kind;
      payload  <= '0;
      position <= '0;
      last     <= 1'b1;
    end else if (cmd.rd_move) begin
      kind     <= KIND_PAYLOAD;
      payload  <= rd_data;
      position <= POS_W'(rd_pos);
      last     <= rd_last;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/byte_stuffing_frame_decoder_unit.sv -----
// Channel   Handshake            Payload
// in        in_valid / in_stall  rx_byte
// out       out_valid/ out_stall kind, payload, position, last
// cfg       cfg_wr_en            cfg_index, cfg_data
//
// One raw byte per cycle while no frame is being released.
// An end byte on a full frame starts a release of FRAME_BYTES results, one per
// cycle from the frame store read port unless output stalls; input stalls till
// the last is loaded. A stalled result register stalls input too.
// Synchronous reset restores the default codes and closes any open frame.
`default_nettype none

`include "byte_stuffing_frame_decoder_unit_macros.svh"

module byte_stuffing_frame_decoder_unit #(
  parameter int FRAME_BYTES = bsfd_pkg::FRAME_BYTES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_wr_en,
  input  wire logic [bsfd_pkg::INDEX_W-1:0]  cfg_index,
  input  wire logic [bsfd_pkg::CODE_W-1:0]   cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [bsfd_pkg::CODE_W-1:0]   rx_byte,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [bsfd_pkg::KIND_W-1:0]        kind,
  output logic [bsfd_pkg::CODE_W-1:0]        payload,
  output logic [bsfd_pkg::POS_W-1:0]         position,
  output logic                               last
);
  import bsfd_pkg::*;

  bsfd_cmd_t cmd;
  bsfd_sts_t sts;

  bsfd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  bsfd_dp #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rx_byte   (rx_byte),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .payload   (payload),
    .position  (position),
    .last      (last)
  );

  `BSFD_ASSERT_NEVER(a_take_in_burst, clk, rst, cmd.take && (cmd.rd_issue || cmd.rd_move))
  `BSFD_ASSERT_IMP(a_rd_blocks_input, clk, rst, sts.rd_vld, in_stall)
  `BSFD_ASSERT_NEXT(a_burst_fresh, clk, rst, cmd.burst_start, !sts.rd_all_issued && !sts.rd_vld)
  `BSFD_ASSERT_IMP(a_error_shape, clk, rst, out_valid && (kind != KIND_PAYLOAD), last && (payload == '0) && (position == '0))

endmodule

`default_nettype wire

// ----- sim/byte_stuffing_frame_decoder_unit_tb.sv -----
module byte_stuffing_frame_decoder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bsfd_pkg::*;

  localparam int FRAME_BYTES  = FRAME_BYTES_DEF;
  localparam int HOLD_CYCLES  = 300;
  localparam int DIRECTED_N   = 27;
  localparam logic [INDEX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum logic [1:0] {PIN_NONE, PIN_QUIET, PIN_SHORT} pin_t;

  typedef struct packed {
    pin_t              pin;
    logic [CODE_W-1:0] raw;
  } stim_row_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CODE_W-1:0] payload;
    logic [POS_W-1:0]  position;
    logic              last;
  } frame_result_t;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                cfg_wr_en = 1'b0;
  logic [INDEX_W-1:0]  cfg_index = '0;
  logic [CODE_W-1:0]   cfg_data  = '0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  logic [CODE_W-1:0]   rx_byte   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [KIND_W-1:0]   kind;
  logic [CODE_W-1:0]   payload;
  logic [POS_W-1:0]    position;
  logic                last;

  pin_t cur_pin      = PIN_NONE;
  logic hold_off_req = 1'b0;

  byte_stuffing_frame_decoder_unit #(
    .FRAME_BYTES(FRAME_BYTES)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .rx_byte   (rx_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .payload   (payload),
    .position  (position),
    .last      (last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // reset codes: begin 02, end 03, escape 1B
  stim_row_t directed_rows [DIRECTED_N] = '{
    '{PIN_QUIET, 8'h1B}, '{PIN_QUIET, 8'h02}, '{PIN_QUIET, 8'h02},
    '{PIN_QUIET, 8'h1B}, '{PIN_QUIET, 8'h1B}, '{PIN_SHORT, 8'h03},
    '{PIN_QUIET, 8'h02}, '{PIN_NONE,  8'h00}, '{PIN_NONE,  8'hFF},
    '{PIN_NONE,  8'h1B}, '{PIN_NONE,  8'h03}, '{PIN_NONE,  8'h55},
    '{PIN_NONE,  8'hAA}, '{PIN_NONE,  8'h02}, '{PIN_NONE,  8'h1B},
    '{PIN_NONE,  8'h1B}, '{PIN_NONE,  8'h01}, '{PIN_NONE,  8'h80},
    '{PIN_NONE,  8'h7F}, '{PIN_NONE,  8'h10}, '{PIN_NONE,  8'h20},
    '{PIN_NONE,  8'h40}, '{PIN_NONE,  8'h08}, '{PIN_NONE,  8'h04},
    '{PIN_NONE,  8'hC3}, '{PIN_NONE,  8'h3C}, '{PIN_NONE,  8'h03}
  };

  // decoder shadow
  logic [CODE_W-1:0] code_begin, code_end, code_escape;
  logic              frame_open, esc_armed, raw_was_esc;
  int                fill_level;
  logic [CODE_W-1:0] frame_data [FRAME_BYTES];
  frame_result_t     step_results [$];
  frame_result_t     expected_results [$];

  int mismatches     = 0;
  int bytes_sent     = 0;
  int results_taken  = 0;
  int frames_out     = 0;
  int shorts_out     = 0;
  int longs_out      = 0;
  int burst_left     = 0;

  function automatic frame_result_t result_of(input logic [KIND_W-1:0] k,
                                              input logic [CODE_W-1:0] p,
                                              input logic [POS_W-1:0] pos,
                                              input logic l);
    frame_result_t r;
    r.kind     = k;
    r.payload  = p;
    r.position = pos;
    r.last     = l;
    return r;
  endfunction

  function void predict_decode(input logic [CODE_W-1:0] raw);
    logic after_esc;
    int   i;
    step_results.delete();
    after_esc   = raw_was_esc;
    raw_was_esc = (raw == code_escape);
    if (!frame_open) begin
      if (raw == code_begin && !after_esc) begin
        frame_open = 1'b1;
        esc_armed  = 1'b0;
        fill_level = 0;
      end
    end else if (fill_level >= FRAME_BYTES) begin
      if (raw == code_end) begin
        for (i = 0; i < FRAME_BYTES; i++)
          step_results.push_back(result_of(KIND_PAYLOAD, frame_data[i], POS_W'(i),
                                           i == FRAME_BYTES - 1));
      end else begin
        step_results.push_back(result_of(KIND_LONG, '0, '0, 1'b1));
      end
      frame_open = 1'b0;
      esc_armed  = 1'b0;
      fill_level = 0;
    end else if (esc_armed) begin
      frame_data[fill_level] = raw;
      fill_level++;
      esc_armed = 1'b0;
    end else if (raw == code_escape) begin
      esc_armed = 1'b1;
    end else if (raw == code_end) begin
      step_results.push_back(result_of(KIND_SHORT, '0, '0, 1'b1));
      frame_open = 1'b0;
      esc_armed  = 1'b0;
      fill_level = 0;
    end else if (raw == code_begin) begin
      // stray begin inside a frame is dropped
    end else begin
      frame_data[fill_level] = raw;
      fill_level++;
    end
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("%0t ns mismatch: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    frame_result_t want;
    if (rst) begin
      code_begin  = BEGIN_RST;
      code_end    = END_RST;
      code_escape = ESCAPE_RST;
      frame_open  = 1'b0;
      esc_armed   = 1'b0;
      raw_was_esc = 1'b0;
      fill_level  = 0;
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        results_taken++;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result kind %0d with nothing expected", kind));
        end else begin
          want = expected_results.pop_front();
          if (kind !== want.kind)
            report_mismatch($sformatf("kind got %0d want %0d", kind, want.kind));
          if (payload !== want.payload)
            report_mismatch($sformatf("payload got %02h want %02h", payload, want.payload));
          if (position !== want.position)
            report_mismatch($sformatf("position got %0d want %0d", position, want.position));
          if (last !== want.last)
            report_mismatch($sformatf("last got %0b want %0b", last, want.last));
          if (want.kind == KIND_SHORT) shorts_out++;
          if (want.kind == KIND_LONG) longs_out++;
          if (want.kind == KIND_PAYLOAD && want.last) frames_out++;
        end
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_BEGIN:  code_begin  = cfg_data;
          REG_END:    code_end    = cfg_data;
          REG_ESCAPE: code_escape = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        predict_decode(rx_byte);
        case (cur_pin)
          PIN_NONE:  foreach (step_results[j]) expected_results.push_back(step_results[j]);
          PIN_SHORT: expected_results.push_back(result_of(KIND_SHORT, '0, '0, 1'b1));
          default: ;
        endcase
      end
    end
  end

  // receiver: stall pattern changes between modes of random length, plus one long hold-off
  initial begin : receiver
    int mode_left;
    int stall_pct;
    int hold_cnt;
    mode_left = 0;
    stall_pct = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++) @(posedge clk);
      end
      if (mode_left == 0) begin
        mode_left = $urandom_range(8, 64);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 20;
          2: stall_pct = 50;
          default: stall_pct = 80;
        endcase
      end
      mode_left--;
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  task automatic send_byte(input logic [CODE_W-1:0] raw, input pin_t pin);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    in_valid <= 1'b1;
    rx_byte  <= raw;
    cur_pin  <= pin;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    burst_left--;
    bytes_sent++;
  endtask

  function automatic logic [CODE_W-1:0] pick_content_byte();
    case ($urandom_range(0, 9))
      0: return code_begin;
      1: return code_end;
      2: return code_escape;
      3: return 8'h00;
      4: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // mostly well-formed frames; some cut short, some overrun, some line noise
  task automatic send_frame(output int body);
    int n_noise, target, ending, i;
    logic [CODE_W-1:0] v;
    body = 0;
    n_noise = $urandom_range(0, 2);
    for (i = 0; i < n_noise; i++) send_byte(8'($urandom), PIN_NONE);
    send_byte(code_begin, PIN_NONE);
    body++;
    ending = $urandom_range(0, 99);
    target = (ending < 15) ? $urandom_range(0, FRAME_BYTES - 1) : FRAME_BYTES;
    for (i = 0; i < target; i++) begin
      if ($urandom_range(0, 99) < 8 && code_begin != code_end && code_begin != code_escape) begin
        send_byte(code_begin, PIN_NONE);
        body++;
      end
      v = pick_content_byte();
      if (v == code_begin || v == code_end || v == code_escape) begin
        send_byte(code_escape, PIN_NONE);
        body++;
      end
      send_byte(v, PIN_NONE);
      body++;
    end
    if (ending >= 15 && ending < 30) begin
      case ($urandom_range(0, 2))
        0: v = code_escape;
        1: v = code_begin;
        default: v = 8'($urandom);
      endcase
      if (v == code_end) v = ~v;
    end else begin
      v = code_end;
    end
    send_byte(v, PIN_NONE);
    body++;
  endtask

  task automatic run_random(input int quota);
    int done, body;
    done = 0;
    while (done < quota) begin
      send_frame(body);
      done += body;
    end
  endtask

  task automatic drain_and_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (FRAME_BYTES + 4) @(posedge clk);
  endtask

  task automatic write_code(input logic [INDEX_W-1:0] idx, input logic [CODE_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : stimulus
    int i;
    int phase;
    logic [CODE_W-1:0] b;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    for (i = 0; i < DIRECTED_N; i++) send_byte(directed_rows[i].raw, directed_rows[i].pin);
    hold_off_req = 1'b1;
    run_random(60);
    drain_and_idle();
    for (phase = 1; phase <= 3; phase++) begin
      case (phase)
        1: begin
          write_code(REG_BEGIN, 8'h00);
          write_code(REG_END, 8'hFF);
          write_code(REG_ESCAPE, 8'h80);
        end
        2: begin
          // begin shares its value with escape
          write_code(REG_BEGIN, 8'hFF);
          write_code(REG_END, 8'h00);
          write_code(REG_ESCAPE, 8'hFF);
          write_code(REG_UNUSED, 8'h5A);
        end
        default: begin
          b = 8'($urandom);
          write_code(REG_BEGIN, b);
          write_code(REG_END, ($urandom_range(0, 1) != 0) ? b : 8'($urandom));
          write_code(REG_ESCAPE, 8'($urandom));
        end
      endcase
      run_random(40);
      drain_and_idle();
    end
    $display("Sent %0d raw byte transfers over 4 code settings, one long output hold-off.",
             bytes_sent);
    $display("Took %0d result transfers: %0d frames, %0d short, %0d long, %0d mismatches.",
             results_taken, frames_out, shorts_out, longs_out, mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #1_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/bsfd_pkg.sv
hw/rtl/bsfd_ctrl.sv
hw/rtl/bsfd_dp.sv
hw/rtl/byte_stuffing_frame_decoder_unit.sv
sim/byte_stuffing_frame_decoder_unit_tb.sv
